FILE: hw/rtl/cft_pkg.sv
package cft_pkg;

  localparam int FIELD_LIMIT_DEF = 16;
  localparam int MAX_RESULTS     = 4;

  localparam logic [4:0] FIELD_CAP_RST = 5'd16;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    RT_CONTENT   = 2'd0,
    RT_FIELD_END = 2'd1,
    RT_LINE_END  = 2'd2
  } rtype_t;

  typedef enum logic [4:0] {
    MODE_FIELD_START = 5'b00001,
    MODE_UNQUOTED    = 5'b00010,
    MODE_QUOTED      = 5'b00100,
    MODE_QUOTE_SEEN  = 5'b01000,
    MODE_LINE_DONE   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    rtype_t     rtype;
    logic [3:0] field_index;
    logic [7:0] out_byte;
    logic [4:0] field_count;
    logic       last_of_run;
  } out_item_t;

  // results of one input item, slot 0 first
  typedef struct packed {
    logic [2:0]                        count;
    out_item_t [MAX_RESULTS-1:0]       slot;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: hw/rtl/cft_front.sv
module cft_front #(
  parameter int FIELD_LIMIT = cft_pkg::FIELD_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cft_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  cft_pkg::q_stat_t  q_stat,
  output logic              push,
  output cft_pkg::bundle_t  push_data
);
  import cft_pkg::*;

  localparam int FSW = $clog2(FIELD_LIMIT + 1);
  localparam int EW  = FSW + 5;

  mode_t          mode_r, mode_nxt;
  logic [FSW-1:0] fs_r, fs_nxt;
  logic [4:0]     field_cap_r;

  function automatic bundle_t add_res(bundle_t b, rtype_t rt, logic [FSW-1:0] fs,
                                      logic [7:0] c);
    logic [EW-1:0] fse;
    logic [EW-1:0] idx;
    bundle_t       r;
    r   = b;
    fse = EW'(fs);
    idx = (fse == '0) ? '0 : fse - 1'b1;
    if (b.count < 3'(MAX_RESULTS)) begin
      r.slot[b.count[1:0]].rtype       = rt;
      r.slot[b.count[1:0]].field_index = idx[3:0];
      r.slot[b.count[1:0]].out_byte    = c;
      r.slot[b.count[1:0]].field_count = fse[4:0];
      r.slot[b.count[1:0]].last_of_run = 1'b0;
      r.count = b.count + 3'd1;
    end
    return r;
  endfunction

  logic [EW-1:0] lim_ext;
  logic [EW-1:0] mf_ext;
  logic [7:0]    c;
  logic          start_c;
  bundle_t       b;

  assign mf_ext  = EW'(field_cap_r);
  assign lim_ext = (mf_ext > EW'(FIELD_LIMIT)) ? EW'(FIELD_LIMIT) : mf_ext;
  assign c       = in_item.in_byte;

  always_comb begin
    b        = '0;
    mode_nxt = mode_r;
    fs_nxt   = fs_r;
    start_c  = 1'b0;
    case (mode_r)
      MODE_FIELD_START: begin
        start_c = 1'b1;
      end
      MODE_UNQUOTED: begin
        if (c == CH_COMMA) begin
          b        = add_res(b, RT_FIELD_END, fs_nxt, CH_NUL);
          mode_nxt = MODE_FIELD_START;
        end else if (c inside {CH_CR, CH_LF, CH_NUL}) begin
          b        = add_res(b, RT_FIELD_END, fs_nxt, CH_NUL);
          mode_nxt = MODE_LINE_DONE;
        end else begin
          b = add_res(b, RT_CONTENT, fs_nxt, c);
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          mode_nxt = MODE_QUOTE_SEEN;
        end else if (c == CH_NUL) begin
          b        = add_res(b, RT_FIELD_END, fs_nxt, CH_NUL);
          mode_nxt = MODE_LINE_DONE;
        end else begin
          b = add_res(b, RT_CONTENT, fs_nxt, c);
        end
      end
      MODE_QUOTE_SEEN: begin
        if (c == CH_QUOTE) begin
          b        = add_res(b, RT_CONTENT, fs_nxt, CH_QUOTE);
          b        = add_res(b, RT_CONTENT, fs_nxt, CH_QUOTE);
          mode_nxt = MODE_QUOTED;
        end else begin
          b = add_res(b, RT_FIELD_END, fs_nxt, CH_NUL);
          if (c == CH_COMMA) begin
            mode_nxt = MODE_FIELD_START;
          end else begin
            start_c = 1'b1;
          end
        end
      end
      default: begin
        mode_nxt = MODE_LINE_DONE;
      end
    endcase

    if (start_c) begin
      if (c == CH_NUL || EW'(fs_nxt) >= lim_ext) begin
        mode_nxt = MODE_LINE_DONE;
      end else begin
        fs_nxt = fs_nxt + 1'b1;
        if (c == CH_QUOTE) begin
          mode_nxt = MODE_QUOTED;
        end else if (c == CH_COMMA) begin
          b        = add_res(b, RT_FIELD_END, fs_nxt, CH_NUL);
          mode_nxt = MODE_FIELD_START;
        end else if (c inside {CH_CR, CH_LF}) begin
          b        = add_res(b, RT_FIELD_END, fs_nxt, CH_NUL);
          mode_nxt = MODE_LINE_DONE;
        end else begin
          b        = add_res(b, RT_CONTENT, fs_nxt, c);
          mode_nxt = MODE_UNQUOTED;
        end
      end
    end

    if (in_item.end_of_line) begin
      if (mode_nxt inside {MODE_UNQUOTED, MODE_QUOTED, MODE_QUOTE_SEEN}) begin
        b = add_res(b, RT_FIELD_END, fs_nxt, CH_NUL);
      end
      b        = add_res(b, RT_LINE_END, '0, CH_NUL);
      b.slot[2'(b.count - 3'd1)].field_count = 5'(EW'(fs_nxt));
      mode_nxt = MODE_FIELD_START;
      fs_nxt   = '0;
    end

    if (b.count != 3'd0) begin
      b.slot[2'(b.count - 3'd1)].last_of_run = 1'b1;
    end
  end

  assign in_ready  = !q_stat.full;
  assign push      = in_valid && in_ready && (b.count != 3'd0);
  assign push_data = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FIELD_START;
      fs_r        <= '0;
      field_cap_r <= FIELD_CAP_RST;
    end else begin
      if (in_valid && in_ready) begin
        mode_r <= mode_nxt;
        fs_r   <= fs_nxt;
      end
      if (cfg_we) begin
        field_cap_r <= cfg_wdata;
      end
    end
  end

endmodule

FILE: hw/rtl/cft_queue.sv
module cft_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cft_pkg::bundle_t push_data,
  input  logic             pop,
  output cft_pkg::bundle_t head,
  output cft_pkg::q_stat_t q_stat
);
  import cft_pkg::*;

  bundle_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_stat.full  = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/cft_back.sv
module cft_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cft_pkg::bundle_t   head,
  input  cft_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cft_pkg::out_item_t out_item
);
  import cft_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       last;

  assign out_valid = !q_stat.empty;
  assign out_item  = head.slot[idx_r];
  assign last      = (3'(idx_r) == head.count - 3'd1);
  assign pop       = out_valid && out_ready && last;

  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

FILE: hw/rtl/csv_field_tokenizer.sv
// CSV field tokenizer.
// Input channel (in_valid/in_ready/in_item): one line byte per item, with
// end_of_line set on the last byte of each line.
// Output channel (out_valid/out_ready/out_item): content bytes with their
// field index, field-end marks and one line-end item per line carrying the
// field count. last_of_run marks the final result of each input item; an
// input item yields zero to four results.
// Config: cfg_we/cfg_wdata write the field cap (most fields started per
// line); write only while idle.
// Results of an item are registered in the result queue before they are
// presented. Throughput: one input item per cycle while each yields at most
// one result and out_ready stays high; the output serialiser presents the
// results of an item one at a time, one per cycle while out_ready is high.
// A two-item queue of result groups sits between parser and serialiser;
// in_ready drops only when it is full, so an output stall backs up into
// the input after two groups.
// Reset (rst_n, synchronous): parser at field start, no fields, queue
// empty, field cap = 16.
module csv_field_tokenizer #(
  parameter int FIELD_LIMIT = cft_pkg::FIELD_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cft_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cft_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);
  import cft_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  bundle_t push_data;
  bundle_t head;

  cft_front #(
    .FIELD_LIMIT(FIELD_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  cft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  cft_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.rtype == RT_LINE_END |->
      out_item.last_of_run && out_item.field_index == 4'd0)
    else $error("line end not last of run or nonzero index");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing queued");

  a_marks_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.rtype != RT_CONTENT |-> out_item.out_byte == 8'h00)
    else $error("mark item carries a byte");
`endif

endmodule

FILE: tb/sv/cft_token_monitor.sv
module cft_token_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cft_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cft_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  output int unsigned        tokens_pending,
  output int unsigned        mismatch_count
);
  import cft_pkg::*;

  localparam int REPORT_LIMIT = 10;

  mode_t       scan_state    = MODE_FIELD_START;
  int unsigned fields_begun  = 0;
  logic [4:0]  field_cap_reg = FIELD_CAP_RST;
  int unsigned errors        = 0;

  out_item_t pending_tokens[$];
  out_item_t run_tokens[$];

  function automatic int unsigned field_cap();
    return (field_cap_reg > FIELD_LIMIT_DEF) ? FIELD_LIMIT_DEF : field_cap_reg;
  endfunction

  function automatic logic [3:0] open_index();
    return 4'((fields_begun == 0) ? 0 : fields_begun - 1);
  endfunction

  function automatic void add_token(rtype_t rt, logic [3:0] idx, logic [7:0] b);
    out_item_t tok;
    if (run_tokens.size() >= MAX_RESULTS) return;
    tok.rtype       = rt;
    tok.field_index = idx;
    tok.out_byte    = b;
    tok.field_count = 5'(fields_begun);
    tok.last_of_run = 1'b0;
    run_tokens.push_back(tok);
  endfunction

  function automatic void begin_field(logic [7:0] c);
    if (c == CH_NUL || fields_begun >= field_cap()) begin
      scan_state = MODE_LINE_DONE;
      return;
    end
    fields_begun++;
    if (c == CH_QUOTE) begin
      scan_state = MODE_QUOTED;
    end else if (c == CH_COMMA) begin
      add_token(RT_FIELD_END, open_index(), 8'h00);
      scan_state = MODE_FIELD_START;
    end else if (c == CH_CR || c == CH_LF) begin
      add_token(RT_FIELD_END, open_index(), 8'h00);
      scan_state = MODE_LINE_DONE;
    end else begin
      add_token(RT_CONTENT, open_index(), c);
      scan_state = MODE_UNQUOTED;
    end
  endfunction

  function automatic void tokenise(logic [7:0] c, logic eol);
    run_tokens.delete();
    case (scan_state)
      MODE_FIELD_START: begin
        begin_field(c);
      end
      MODE_UNQUOTED: begin
        if (c == CH_COMMA) begin
          add_token(RT_FIELD_END, open_index(), 8'h00);
          scan_state = MODE_FIELD_START;
        end else if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
          add_token(RT_FIELD_END, open_index(), 8'h00);
          scan_state = MODE_LINE_DONE;
        end else begin
          add_token(RT_CONTENT, open_index(), c);
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          scan_state = MODE_QUOTE_SEEN;
        end else if (c == CH_NUL) begin
          add_token(RT_FIELD_END, open_index(), 8'h00);
          scan_state = MODE_LINE_DONE;
        end else begin
          add_token(RT_CONTENT, open_index(), c);
        end
      end
      MODE_QUOTE_SEEN: begin
        if (c == CH_QUOTE) begin
          add_token(RT_CONTENT, open_index(), CH_QUOTE);
          add_token(RT_CONTENT, open_index(), CH_QUOTE);
          scan_state = MODE_QUOTED;
        end else begin
          add_token(RT_FIELD_END, open_index(), 8'h00);
          if (c == CH_COMMA) scan_state = MODE_FIELD_START;
          else begin_field(c);
        end
      end
      default: begin
        scan_state = MODE_LINE_DONE;
      end
    endcase
    if (eol) begin
      // end of line closes any open field, quoted or not
      if (scan_state == MODE_UNQUOTED || scan_state == MODE_QUOTED ||
          scan_state == MODE_QUOTE_SEEN)
        add_token(RT_FIELD_END, open_index(), 8'h00);
      add_token(RT_LINE_END, 4'd0, 8'h00);
      scan_state   = MODE_FIELD_START;
      fields_begun = 0;
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
    foreach (run_tokens[i]) pending_tokens.push_back(run_tokens[i]);
  endfunction

  function automatic void check_token(out_item_t got);
    out_item_t want;
    if (pending_tokens.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("unexpected item: type %0d idx %0d byte %02h cnt %0d last %0b",
                 got.rtype, got.field_index, got.out_byte, got.field_count,
                 got.last_of_run);
      return;
    end
    want = pending_tokens.pop_front();
    if (got.rtype !== want.rtype || got.field_index !== want.field_index ||
        got.out_byte !== want.out_byte || got.field_count !== want.field_count ||
        got.last_of_run !== want.last_of_run) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("mismatch: exp type %0d idx %0d byte %02h cnt %0d last %0b, %s",
                 want.rtype, want.field_index, want.out_byte, want.field_count,
                 want.last_of_run,
                 $sformatf("got type %0d idx %0d byte %02h cnt %0d last %0b",
                           got.rtype, got.field_index, got.out_byte,
                           got.field_count, got.last_of_run));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_tokens.delete();
      scan_state    = MODE_FIELD_START;
      fields_begun  = 0;
      field_cap_reg = FIELD_CAP_RST;
    end else begin
      if (cfg_we) field_cap_reg = cfg_wdata;
      if (out_valid && out_ready) check_token(out_item);
      if (in_valid && in_ready) tokenise(in_item.in_byte, in_item.end_of_line);
    end
    tokens_pending <= pending_tokens.size();
    mismatch_count <= errors;
  end

endmodule

FILE: tb/sv/tb_csv_field_tokenizer.sv
module tb_csv_field_tokenizer;

  import cft_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DIRECTED_ITEMS = 25;
  localparam int PHASE_ITEMS    = 48;
  localparam int N_PHASES       = 8;
  localparam logic [4:0] PHASE_CAPS [N_PHASES] =
    '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd17, 5'd5, 5'd16};

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [4:0] cfg_wdata = '0;

  int unsigned tokens_pending;
  int unsigned mismatch_count;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned bytes_sent   = 0;
  int unsigned cycle_count  = 0;

  csv_field_tokenizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cft_token_monitor i_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .tokens_pending (tokens_pending),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_csv_field_tokenizer NOT OK");
      $finish;
    end
  end

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(7) == 0) return 8'($urandom_range(128, 255));
    do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE || c == CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_CR;
      3: return CH_LF;
      4: return CH_NUL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eol);
    in_item_t item;
    item.in_byte     = b;
    item.end_of_line = eol;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // mostly well-formed records with random content, some noise
  task automatic send_line(input int n_fields);
    logic [7:0] text[$];
    int len;
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) text.push_back(CH_COMMA);
      len = $urandom_range(4);
      case ($urandom_range(7))
        0, 1, 2, 3: begin
          repeat (len) text.push_back(plain_char());
        end
        4, 5, 6: begin
          text.push_back(CH_QUOTE);
          repeat (len) begin
            case ($urandom_range(5))
              0: begin
                text.push_back(CH_QUOTE);
                text.push_back(CH_QUOTE);
              end
              1: text.push_back(noise_char());
              default: text.push_back(plain_char());
            endcase
          end
          text.push_back(CH_QUOTE);
        end
        default: begin
          repeat (len + 1) text.push_back(noise_char());
        end
      endcase
    end
    case ($urandom_range(3))
      1: text.push_back(CH_CR);
      2: begin
        text.push_back(CH_CR);
        text.push_back(CH_LF);
      end
      3: text.push_back(CH_LF);
      default: ;
    endcase
    if (text.size() == 0) text.push_back(plain_char());
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tokens_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_cap(input logic [4:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("x");
    send_text(",");
    send_text("\"\"\"");
    send_text("\"q\"z");
    send_text("\ry");
    send_byte("a", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte("b", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_LF, 1'b1);
    send_text("\"a,\n\"");
    send_byte(CH_NUL, 1'b1);
    send_text("\"\",b");

    for (int p = 0; p < N_PHASES; p++) begin
      set_max_cap(PHASE_CAPS[p]);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 61;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 61;
        end
        default: begin
          tx_idle_pct  = 38;
          rx_stall_pct = 38;
        end
      endcase
      while (bytes_sent < DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS)
        send_line(($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5));
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_csv_field_tokenizer OK");
    end else begin
      $display("tb_csv_field_tokenizer NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cft_pkg.sv
hw/rtl/cft_front.sv
hw/rtl/cft_queue.sv
hw/rtl/cft_back.sv
hw/rtl/csv_field_tokenizer.sv
tb/sv/cft_token_monitor.sv
tb/sv/tb_csv_field_tokenizer.sv
